[rtl/spbd_pkg.sv]
// ============================================================================
// Space packet byte deframer package
// Shared types, constants and register codes for the deframer.
// ============================================================================
package spbd_pkg;

    // Packet geometry.
    localparam int SYNC_LEN        = 2;
    localparam int PRIMARY_BYTES   = 6;
    localparam int SECONDARY_BYTES = 5;
    localparam int PRIM_END        = SYNC_LEN + PRIMARY_BYTES;
    localparam int SEC_END         = PRIM_END + SECONDARY_BYTES;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 17;
    localparam int SEC_W  = 3;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;

    typedef enum logic [0:0] {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CAND = 3'd1,
        PH_PRIM = 3'd2,
        PH_SEC  = 3'd3,
        PH_BODY = 3'd4
    } t_phase;

    typedef enum logic [SEC_W-1:0] {
        SEC_HUNT   = 3'd0,
        SEC_SYNC   = 3'd1,
        SEC_PRIM   = 3'd2,
        SEC_SECOND = 3'd3,
        SEC_BODY   = 3'd4
    } t_section;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_section          section;
        logic [CNT_W-1:0]  offset;
        logic              packet_done;
        logic [CNT_W-1:0]  body_length;
    } t_result;

endpackage

[rtl/spbd_cfg_regs.sv]
// ============================================================================
// Deframer configuration registers
// APB-style register file holding the two sync bytes.
// ============================================================================
module spbd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spbd_pkg::ADDR_W-1:0]    paddr,
    input  logic [spbd_pkg::DATA_W-1:0]    pwdata,
    output logic [spbd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output spbd_pkg::t_cfg                 o_cfg
);

    logic [spbd_pkg::BYTE_W-1:0] r_sync_first;
    logic [spbd_pkg::BYTE_W-1:0] r_sync_second;
    spbd_pkg::t_reg_index        reg_index;
    logic                        wr_en;

    // Registers sit on word boundaries; the low address bits are ignored.
    assign reg_index = spbd_pkg::t_reg_index'(paddr[2]);
    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= spbd_pkg::SYNC_FIRST_RST;
            r_sync_second <= spbd_pkg::SYNC_SECOND_RST;
        end else if (wr_en) begin
            unique case (reg_index)
                spbd_pkg::REG_SYNC_FIRST:  r_sync_first  <= pwdata[spbd_pkg::BYTE_W-1:0];
                spbd_pkg::REG_SYNC_SECOND: r_sync_second <= pwdata[spbd_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            spbd_pkg::REG_SYNC_FIRST:  prdata[spbd_pkg::BYTE_W-1:0] = r_sync_first;
            spbd_pkg::REG_SYNC_SECOND: prdata[spbd_pkg::BYTE_W-1:0] = r_sync_second;
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.sync_first  = r_sync_first;
    assign o_cfg.sync_second = r_sync_second;

endmodule

[rtl/spbd_core.sv]
// ============================================================================
// Deframer core
// Input byte register, packet phase tracker and result formation.
// ============================================================================
module spbd_core #(
    parameter int PRIMARY_BYTES   = spbd_pkg::PRIMARY_BYTES,
    parameter int SECONDARY_BYTES = spbd_pkg::SECONDARY_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spbd_pkg::t_cfg                i_cfg,
    input  logic                          i_up_valid,
    output logic                          o_up_ready,
    input  logic [spbd_pkg::BYTE_W-1:0]   i_up_byte,
    output logic                          o_dn_valid,
    input  logic                          i_dn_ready,
    output spbd_pkg::t_result             o_dn_result
);

    localparam int CW       = spbd_pkg::CNT_W;
    localparam int PRIM_END = spbd_pkg::SYNC_LEN + PRIMARY_BYTES;
    localparam int SEC_END  = PRIM_END + SECONDARY_BYTES;

    logic                        r_in_valid;
    logic [spbd_pkg::BYTE_W-1:0] r_in_byte;

    spbd_pkg::t_phase            r_phase, n_phase;
    logic [CW-1:0]               r_count, n_count;
    logic [spbd_pkg::BYTE_W-1:0] r_last, n_last;
    logic [spbd_pkg::BYTE_W-1:0] r_len_high, n_len_high;
    logic [CW-1:0]               r_pkt_len, n_pkt_len;

    spbd_pkg::t_section          sec;
    logic [CW-1:0]               off;
    logic                        done;
    logic [CW-1:0]               len_out;
    logic                        advance;
    logic                        up_acc;

    assign advance    = r_in_valid & i_dn_ready;
    assign o_up_ready = ~r_in_valid | i_dn_ready;
    assign up_acc     = i_up_valid & o_up_ready;
    assign o_dn_valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (up_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (up_acc) begin
            r_in_byte <= i_up_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= spbd_pkg::PH_HUNT;
            r_count    <= '0;
            r_last     <= '0;
            r_len_high <= '0;
            r_pkt_len  <= '0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_last     <= n_last;
            r_len_high <= n_len_high;
            r_pkt_len  <= n_pkt_len;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_last     = r_last;
        n_len_high = r_len_high;
        n_pkt_len  = r_pkt_len;
        sec        = spbd_pkg::SEC_HUNT;
        off        = '0;
        done       = 1'b0;

        unique case (r_phase)
            spbd_pkg::PH_CAND: begin
                if (r_last == i_cfg.sync_first && r_in_byte == i_cfg.sync_second) begin
                    sec       = spbd_pkg::SEC_SYNC;
                    off       = CW'(1);
                    n_phase   = spbd_pkg::PH_PRIM;
                    n_count   = CW'(spbd_pkg::SYNC_LEN);
                    n_pkt_len = '0;
                end else begin
                    // Slide the hunt: the new byte becomes the candidate.
                    n_last  = r_in_byte;
                    n_phase = spbd_pkg::PH_CAND;
                    n_count = CW'(1);
                    sec     = (r_in_byte == i_cfg.sync_first) ? spbd_pkg::SEC_SYNC
                                                              : spbd_pkg::SEC_HUNT;
                end
            end
            spbd_pkg::PH_PRIM: begin
                sec = spbd_pkg::SEC_PRIM;
                off = r_count;
                if (r_count == CW'(PRIM_END - 2)) begin
                    n_len_high = r_in_byte;
                end
                if (r_count == CW'(PRIM_END - 1)) begin
                    n_pkt_len = {1'b0, r_len_high, r_in_byte} + CW'(1);
                    n_phase   = (SECONDARY_BYTES > 0) ? spbd_pkg::PH_SEC
                                                      : spbd_pkg::PH_BODY;
                end
                n_count = r_count + CW'(1);
            end
            spbd_pkg::PH_SEC: begin
                sec = spbd_pkg::SEC_SECOND;
                off = r_count;
                if (r_count >= CW'(SEC_END - 1)) begin
                    if (r_pkt_len <= CW'(SECONDARY_BYTES)) begin
                        done = 1'b1;
                    end else begin
                        n_phase = spbd_pkg::PH_BODY;
                    end
                end
                n_count = r_count + CW'(1);
            end
            spbd_pkg::PH_BODY: begin
                sec = spbd_pkg::SEC_BODY;
                off = r_count;
                if (({1'b0, r_count} + (CW+1)'(1))
                        >= ((CW+1)'(PRIM_END) + {1'b0, r_pkt_len})) begin
                    done = 1'b1;
                end
                n_count = r_count + CW'(1);
            end
            default: begin
                n_last  = r_in_byte;
                n_phase = spbd_pkg::PH_CAND;
                n_count = CW'(1);
                sec     = (r_in_byte == i_cfg.sync_first) ? spbd_pkg::SEC_SYNC
                                                          : spbd_pkg::SEC_HUNT;
            end
        endcase

        len_out = n_pkt_len;
        if (done) begin
            n_phase   = spbd_pkg::PH_HUNT;
            n_count   = '0;
            n_pkt_len = '0;
        end
    end

    assign o_dn_result.out_byte    = r_in_byte;
    assign o_dn_result.section     = sec;
    assign o_dn_result.offset      = off;
    assign o_dn_result.packet_done = done;
    assign o_dn_result.body_length = len_out;

endmodule

[rtl/spbd_out_skid.sv]
// ============================================================================
// Deframer output skid buffer
// Two-entry result register that keeps the upstream ready registered.
// ============================================================================
module spbd_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_up_valid,
    output logic               o_up_ready,
    input  spbd_pkg::t_result  i_up_data,
    output logic               o_dn_valid,
    input  logic               i_dn_ready,
    output spbd_pkg::t_result  o_dn_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    spbd_pkg::t_result r_main;
    spbd_pkg::t_result r_skid;
    logic              up_acc;
    logic              dn_take;

    assign o_up_ready = ~r_skid_valid;
    assign up_acc     = i_up_valid & o_up_ready;
    assign dn_take    = r_main_valid & i_dn_ready;
    assign o_dn_valid = r_main_valid;
    assign o_dn_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (dn_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (up_acc) begin
            if (r_main_valid && !dn_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (dn_take) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (dn_take) begin
                r_main <= r_skid;
            end
        end else if (up_acc) begin
            if (r_main_valid && !dn_take) begin
                r_skid <= i_up_data;
            end else begin
                r_main <= i_up_data;
            end
        end
    end

endmodule

[rtl/space_packet_byte_deframer_unit.sv]
// ============================================================================
// Space packet byte deframer
// Hunts for a two-byte sync word, walks the primary header, secondary header
// and body of each packet, and tags every received byte with its section.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -------------------------------
//  rx        in         i_valid / o_ready         i_rx_byte
//  result    out        o_valid / i_ready         o_out_byte, o_section, o_offset,
//                                                 o_packet_done, o_body_length
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One beat is taken per clock cycle, sustained while the result side keeps
// up, and every input beat makes exactly one result beat. A byte is held in
// the input register, where the phase tracker evaluates it, and then lands
// in the result register of the output skid buffer, which presents it.
// Reset is synchronous and active low; it returns the tracker to hunting and
// restores the sync bytes to 0x55 and 0xAA. There is no clearing pass.
// A stall on the result side fills the result register, the skid entry and
// the input register, three beats in all, and then drops o_ready; o_ready
// comes from registers only, never from i_ready directly.
//
// The sync hunt slides: a byte that breaks a sync pair becomes the new
// candidate first sync byte instead of being thrown away. The length field is
// taken big-endian from the last two primary-header bytes and incremented by
// one; a packet never ends before the end of its secondary header.
// ============================================================================
module space_packet_byte_deframer_unit #(
    parameter int PRIMARY_BYTES   = spbd_pkg::PRIMARY_BYTES,
    parameter int SECONDARY_BYTES = spbd_pkg::SECONDARY_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Received byte channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [spbd_pkg::BYTE_W-1:0]   i_rx_byte,
    // Tagged byte channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [spbd_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [spbd_pkg::SEC_W-1:0]    o_section,
    output logic [spbd_pkg::CNT_W-1:0]    o_offset,
    output logic                          o_packet_done,
    output logic [spbd_pkg::CNT_W-1:0]    o_body_length,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [spbd_pkg::DATA_W-1:0]   pwdata,
    output logic [spbd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    spbd_pkg::t_cfg    cfg;
    spbd_pkg::t_result core_result;
    spbd_pkg::t_result out_result;
    logic              core_valid;
    logic              skid_ready;

    // Sync byte registers behind the APB-style port.
    spbd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register plus the phase tracker. The tracker state advances only
    // when the skid buffer takes the current byte's result.
    spbd_core #(
        .PRIMARY_BYTES   (PRIMARY_BYTES),
        .SECONDARY_BYTES (SECONDARY_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_up_valid  (i_valid),
        .o_up_ready  (o_ready),
        .i_up_byte   (i_rx_byte),
        .o_dn_valid  (core_valid),
        .i_dn_ready  (skid_ready),
        .o_dn_result (core_result)
    );

    // Result register with a skid entry, so a stalled consumer never blocks
    // the byte already in flight.
    spbd_out_skid u_out_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (core_valid),
        .o_up_ready (skid_ready),
        .i_up_data  (core_result),
        .o_dn_valid (o_valid),
        .i_dn_ready (i_ready),
        .o_dn_data  (out_result)
    );

    assign o_out_byte    = out_result.out_byte;
    assign o_section     = out_result.section;
    assign o_offset      = out_result.offset;
    assign o_packet_done = out_result.packet_done;
    assign o_body_length = out_result.body_length;

endmodule

[rtl/spbd_checker.sv]
// ============================================================================
// Deframer port checker
// Concurrent checks on the result channel of the deframer, bound to the top.
// ============================================================================
module spbd_checker #(
    parameter int PRIMARY_BYTES = spbd_pkg::PRIMARY_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [spbd_pkg::BYTE_W-1:0]   o_out_byte,
    input  logic [spbd_pkg::SEC_W-1:0]    o_section,
    input  logic [spbd_pkg::CNT_W-1:0]    o_offset,
    input  logic                          o_packet_done,
    input  logic [spbd_pkg::CNT_W-1:0]    o_body_length
);

    localparam int PRIM_END = spbd_pkg::SYNC_LEN + PRIMARY_BYTES;

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_section)
            && $stable(o_offset) && $stable(o_packet_done) && $stable(o_body_length))
        else $error("result beat changed while stalled");

    // A packet only ends in the secondary header or the body.
    a_done_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_done |->
            o_section == spbd_pkg::SEC_SECOND || o_section == spbd_pkg::SEC_BODY)
        else $error("packet done outside secondary header or body");

    // Hunting and sync bytes carry no length and sit at the packet start.
    a_hunt_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_section == spbd_pkg::SEC_HUNT || o_section == spbd_pkg::SEC_SYNC) |->
            o_body_length == '0 && !o_packet_done && o_offset <= spbd_pkg::CNT_W'(1))
        else $error("hunt or sync beat with stray length, offset or done");

    // Primary header bytes lie between the sync word and the header end.
    a_prim_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_section == spbd_pkg::SEC_PRIM |->
            o_offset >= spbd_pkg::CNT_W'(spbd_pkg::SYNC_LEN)
            && o_offset < spbd_pkg::CNT_W'(PRIM_END))
        else $error("primary header beat at offset outside the header");

endmodule

bind space_packet_byte_deframer_unit spbd_checker #(
    .PRIMARY_BYTES (PRIMARY_BYTES)
) u_spbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_section     (o_section),
    .o_offset      (o_offset),
    .o_packet_done (o_packet_done),
    .o_body_length (o_body_length)
);
